// File: sv/usb_endpoint_transfer_segmenter_unit_macros.svh
// Assertion macros for the endpoint transfer segmenter.
// Used by the top level; no other dependencies.
`ifndef USB_ENDPOINT_TRANSFER_SEGMENTER_UNIT_MACROS_SVH
`define USB_ENDPOINT_TRANSFER_SEGMENTER_UNIT_MACROS_SVH

// Clocked check, quiet while reset is asserted.
`define USB_ETS_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("usb_ets: check failed");

// Clocked check that also holds during reset.
`define USB_ETS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("usb_ets: check failed");

`endif

// File: sv/usb_ets_pkg.sv
// Shared types, constants and helpers of the endpoint transfer segmenter.
// No dependencies.
`timescale 1ns / 1ps

package usb_ets_pkg;

    localparam int NUM_ENDPOINTS = 8;
    localparam int LEN_BITS      = 16;
    localparam int NREC          = 2 * NUM_ENDPOINTS;
    localparam int REC_BITS      = $clog2(NREC);
    localparam int EP_BITS       = 3;
    localparam int MPS_BITS      = 11;
    localparam int ADDR_BITS     = 32;
    localparam int FIELD_LEN_BITS = 16;
    localparam int EP_CMP_BITS   = 5;

    localparam logic [ADDR_BITS-1:0] ADDR_ALIGN_MASK = ADDR_BITS'(32'h03);
    localparam logic [1:0]           TYPE_BULK       = 2'd2;

    typedef enum logic [1:0] {
        MODE_OPEN  = 2'd0,
        MODE_START = 2'd1,
        MODE_DONE  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK        = 3'd0,
        STAT_NULL_BUF  = 3'd1,
        STAT_DISABLED  = 3'd2,
        STAT_MISALIGN  = 3'd3,
        STAT_BUSY      = 3'd4
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        mode_t                  mode;
        logic                   dir_in;
        logic [EP_BITS-1:0]     endpoint;
        logic [1:0]             ep_type;
        logic [MPS_BITS-1:0]    max_packet;
        logic [ADDR_BITS-1:0]   buffer_addr;
        logic [LEN_BITS-1:0]    len;
        logic [MPS_BITS-1:0]    received_count;
    } item_t;

    typedef struct packed {
        logic [MPS_BITS-1:0]    max_packet;
        logic [LEN_BITS-1:0]    remaining;
        logic [LEN_BITS-1:0]    done;
        logic [ADDR_BITS-1:0]   dma_addr;
    } rec_t;

    typedef struct packed {
        logic enabled;
        logic burst;
        logic armed;
    } flags_t;

    typedef struct packed {
        logic open_we;
        logic burst;
        logic armed_we;
        logic armed;
    } flag_upd_t;

    typedef struct packed {
        status_t                    status;
        logic                       armed;
        logic [FIELD_LEN_BITS-1:0]  packet_len;
        logic [ADDR_BITS-1:0]       dma_addr;
        logic                       complete;
        logic [FIELD_LEN_BITS-1:0]  done_len;
    } res_t;

    function automatic logic [LEN_BITS-1:0] len_min(input logic [LEN_BITS-1:0] a,
                                                     input logic [LEN_BITS-1:0] b);
        return (a < b) ? a : b;
    endfunction

endpackage

// File: sv/usb_ets_rec_ram.sv
// Endpoint record memory: one write port, one registered read port.
// Depends on usb_ets_pkg for the record type and depth.
`timescale 1ns / 1ps

module usb_ets_rec_ram (
    input  logic                              aclk,
    input  logic                              rd_en,
    input  logic [usb_ets_pkg::REC_BITS-1:0]  rd_addr,
    output usb_ets_pkg::rec_t                 rd_data,
    input  logic                              wr_en,
    input  logic [usb_ets_pkg::REC_BITS-1:0]  wr_addr,
    input  usb_ets_pkg::rec_t                 wr_data
);
    import usb_ets_pkg::*;

    rec_t mem [NREC];
    rec_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/usb_ets_exec.sv
// Record update for one item: checks, packet advance, result word.
// Depends on usb_ets_pkg.
`timescale 1ns / 1ps

module usb_ets_exec (
    input  usb_ets_pkg::item_t     item_i,
    input  usb_ets_pkg::flags_t    flags_i,
    input  usb_ets_pkg::rec_t      rec_i,
    output usb_ets_pkg::res_t      res_o,
    output usb_ets_pkg::rec_t      rec_o,
    output logic                   rec_we_o,
    output usb_ets_pkg::flag_upd_t upd_o
);
    import usb_ets_pkg::*;

    logic                ep_ok;
    logic [LEN_BITS-1:0] mps_l;
    logic [LEN_BITS-1:0] rc_l;
    logic [LEN_BITS-1:0] rem_new;
    logic [LEN_BITS-1:0] done_new;

    assign ep_ok = (item_i.endpoint != '0) &&
                   (EP_CMP_BITS'(item_i.endpoint) < EP_CMP_BITS'(NUM_ENDPOINTS));
    assign mps_l = LEN_BITS'(rec_i.max_packet);
    assign rc_l  = LEN_BITS'(item_i.received_count);

    always_comb begin
        res_o    = '0;
        rec_o    = rec_i;
        rec_we_o = 1'b0;
        upd_o    = '0;
        rem_new  = rec_i.remaining;
        done_new = rec_i.done;
        if (item_i.mode == MODE_NONE) begin
            res_o = '0;
        end else if (!ep_ok) begin
            res_o.status = STAT_DISABLED;
        end else begin
            unique case (item_i.mode)
                MODE_OPEN: begin
                    upd_o.open_we    = 1'b1;
                    upd_o.burst      = (item_i.ep_type == TYPE_BULK);
                    upd_o.armed_we   = 1'b1;
                    upd_o.armed      = 1'b0;
                    rec_o.max_packet = item_i.max_packet;
                    rec_we_o         = 1'b1;
                end
                MODE_START: begin
                    priority if (item_i.buffer_addr == '0 && item_i.len != '0) begin
                        res_o.status = STAT_NULL_BUF;
                    end else if (!flags_i.enabled) begin
                        res_o.status = STAT_DISABLED;
                    end else if ((item_i.buffer_addr & ADDR_ALIGN_MASK) != '0) begin
                        res_o.status = STAT_MISALIGN;
                    end else if (item_i.dir_in && flags_i.armed) begin
                        res_o.status = STAT_BUSY;
                    end else begin
                        rec_o.remaining  = item_i.len;
                        rec_o.done       = '0;
                        rec_o.dma_addr   = item_i.buffer_addr;
                        rec_we_o         = 1'b1;
                        upd_o.armed_we   = 1'b1;
                        upd_o.armed      = 1'b1;
                        res_o.armed      = 1'b1;
                        res_o.packet_len = FIELD_LEN_BITS'(flags_i.burst ? item_i.len :
                                               len_min(item_i.len, mps_l));
                        res_o.dma_addr   = item_i.buffer_addr;
                    end
                end
                MODE_DONE: begin
                    if (!flags_i.enabled) begin
                        res_o.status = STAT_DISABLED;
                    end else if (flags_i.armed) begin
                        upd_o.armed_we = 1'b1;
                        upd_o.armed    = 1'b0;
                        if (flags_i.burst) begin
                            res_o.complete = 1'b1;
                            res_o.done_len = item_i.dir_in ?
                                FIELD_LEN_BITS'(rec_i.remaining) : FIELD_LEN_BITS'(rc_l);
                        end else if (item_i.dir_in) begin
                            rec_we_o = 1'b1;
                            if (rec_i.remaining > mps_l) begin
                                rem_new          = rec_i.remaining - mps_l;
                                rec_o.remaining  = rem_new;
                                rec_o.done       = rec_i.done + mps_l;
                                rec_o.dma_addr   = rec_i.dma_addr +
                                                   ADDR_BITS'(rec_i.max_packet);
                                upd_o.armed      = 1'b1;
                                res_o.armed      = 1'b1;
                                res_o.packet_len = FIELD_LEN_BITS'(len_min(rem_new, mps_l));
                                res_o.dma_addr   = rec_o.dma_addr;
                            end else begin
                                done_new        = rec_i.done + rec_i.remaining;
                                rec_o.done      = done_new;
                                rec_o.remaining = '0;
                                res_o.complete  = 1'b1;
                                res_o.done_len  = FIELD_LEN_BITS'(done_new);
                            end
                        end else begin
                            rec_we_o        = 1'b1;
                            done_new        = rec_i.done + rc_l;
                            rem_new         = (rec_i.remaining > rc_l) ?
                                              (rec_i.remaining - rc_l) : '0;
                            rec_o.done      = done_new;
                            rec_o.remaining = rem_new;
                            if (rc_l < mps_l || rem_new == '0) begin
                                res_o.complete = 1'b1;
                                res_o.done_len = FIELD_LEN_BITS'(done_new);
                            end else begin
                                rec_o.dma_addr   = rec_i.dma_addr +
                                                   ADDR_BITS'(rec_i.max_packet);
                                upd_o.armed      = 1'b1;
                                res_o.armed      = 1'b1;
                                res_o.packet_len = FIELD_LEN_BITS'(len_min(rem_new, mps_l));
                                res_o.dma_addr   = rec_o.dma_addr;
                            end
                        end
                    end
                end
                MODE_NONE: begin
                    res_o = '0;
                end
            endcase
        end
    end

endmodule

// File: sv/usb_endpoint_transfer_segmenter_unit.sv
// Top level of the USB endpoint transfer segmenter.
// Depends on usb_ets_pkg, usb_ets_rec_ram, usb_ets_exec and the macros header.
//
//   channel | prefix | direction | word carries
//   --------+--------+-----------+------------------------------------------
//   command | s_     | in        | mode, direction, endpoint, open/start args
//   result  | m_     | out       | status, armed packet, completion
//
// Steps: the endpoint record is read from the record RAM (registered read port)
//   as the word is accepted in S_IDLE, then updated and written back in S_EXEC.
// Stalls: a result held in the output register by m_ready low holds the
//   update cycle; the next word is taken only after the write-back.
// Reset: aresetn clears the enabled, burst and armed flags; the record RAM is
//   not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`include "usb_endpoint_transfer_segmenter_unit_macros.svh"

module usb_endpoint_transfer_segmenter_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_mode,
    input  logic                                   s_dir_in,
    input  logic [usb_ets_pkg::EP_BITS-1:0]        s_endpoint,
    input  logic [1:0]                             s_ep_type,
    input  logic [usb_ets_pkg::MPS_BITS-1:0]       s_max_packet,
    input  logic [usb_ets_pkg::ADDR_BITS-1:0]      s_buffer_addr,
    input  logic [usb_ets_pkg::FIELD_LEN_BITS-1:0] s_length,
    input  logic [usb_ets_pkg::MPS_BITS-1:0]       s_received_count,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [2:0]                             m_status,
    output logic                                   m_armed,
    output logic [usb_ets_pkg::FIELD_LEN_BITS-1:0] m_packet_len,
    output logic [usb_ets_pkg::ADDR_BITS-1:0]      m_dma_addr,
    output logic                                   m_complete,
    output logic [usb_ets_pkg::FIELD_LEN_BITS-1:0] m_done_len
);
    import usb_ets_pkg::*;

    state_t              state_reg;
    state_t              state_next;
    logic                s_accept;
    logic                exec_fire;
    logic [REC_BITS-1:0] s_index;
    logic [REC_BITS-1:0] k_reg;
    item_t               item_reg;
    logic [NREC-1:0]     en_reg;
    logic [NREC-1:0]     burst_reg;
    logic [NREC-1:0]     armed_reg;
    flags_t              flags;
    rec_t                rec_rd;
    rec_t                rec_wr;
    logic                rec_we;
    flag_upd_t           upd;
    res_t                res;
    res_t                res_reg;
    logic                m_valid_reg;
    logic                m_valid_next;

    // Record index: direction selects the upper half of the table.
    assign s_index = REC_BITS'(32'(s_dir_in) * NUM_ENDPOINTS + 32'(s_endpoint));

    // Next-state logic: read cycle, then update once the result register frees up.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    // Output logic of the sequencer.
    always_comb begin
        s_ready   = 1'b0;
        exec_fire = 1'b0;
        unique case (state_reg)
            S_IDLE: s_ready   = 1'b1;
            S_EXEC: exec_fire = !m_valid_reg || m_ready;
        endcase
    end

    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the accepted word and its record index for the update cycle.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.mode           <= mode_t'(s_mode);
            item_reg.dir_in         <= s_dir_in;
            item_reg.endpoint       <= s_endpoint;
            item_reg.ep_type        <= s_ep_type;
            item_reg.max_packet     <= s_max_packet;
            item_reg.buffer_addr    <= s_buffer_addr;
            item_reg.len            <= LEN_BITS'(s_length);
            item_reg.received_count <= s_received_count;
            k_reg                   <= s_index;
        end
    end

    // The write-back lands before the next read can be issued,
    // so a back-to-back access to the same record always sees fresh data.
    usb_ets_rec_ram u_rec_ram (
        .aclk    (aclk),
        .rd_en   (s_accept),
        .rd_addr (s_index),
        .rd_data (rec_rd),
        .wr_en   (exec_fire && rec_we),
        .wr_addr (k_reg),
        .wr_data (rec_wr)
    );

    assign flags.enabled = en_reg[k_reg];
    assign flags.burst   = burst_reg[k_reg];
    assign flags.armed   = armed_reg[k_reg];

    usb_ets_exec u_exec (
        .item_i   (item_reg),
        .flags_i  (flags),
        .rec_i    (rec_rd),
        .res_o    (res),
        .rec_o    (rec_wr),
        .rec_we_o (rec_we),
        .upd_o    (upd)
    );

    // Per-record flags live in flops so reset clears them at once.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg    <= '0;
            burst_reg <= '0;
            armed_reg <= '0;
        end else if (exec_fire) begin
            if (upd.open_we) begin
                en_reg[k_reg]    <= 1'b1;
                burst_reg[k_reg] <= upd.burst;
            end
            if (upd.armed_we) begin
                armed_reg[k_reg] <= upd.armed;
            end
        end
    end

    // Result register: load on update, drop once taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (exec_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_fire) begin
            res_reg <= res;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = res_reg.status;
    assign m_armed      = res_reg.armed;
    assign m_packet_len = res_reg.packet_len;
    assign m_dma_addr   = res_reg.dma_addr;
    assign m_complete   = res_reg.complete;
    assign m_done_len   = res_reg.done_len;

    // A record can only be armed after it has been opened.
    `USB_ETS_ASSERT(a_armed_needs_enable, aclk, aresetn, (armed_reg & ~en_reg) == '0)
    // Every update cycle leaves a result waiting.
    `USB_ETS_ASSERT(a_fire_loads_result, aclk, aresetn, exec_fire |=> m_valid)
    // A pending result that is not taken holds the update cycle.
    `USB_ETS_ASSERT(a_stall_holds_exec, aclk, aresetn, (state_reg == S_EXEC && m_valid_reg && !m_ready) |=> state_reg == S_EXEC)
    // An armed packet is only reported with good status and no completion.
    `USB_ETS_ASSERT(a_armed_result_ok, aclk, aresetn, (m_valid && m_armed) |-> (m_status == STAT_OK && !m_complete))

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the USB endpoint transfer segmenter.
// Depends on usb_ets_pkg and usb_endpoint_transfer_segmenter_unit.
// A clocked driver and monitor run against an in-bench model of the endpoint records.
`timescale 1ns / 1ps

module tb_top;
    import usb_ets_pkg::*;

    // Run limit, far above the slowest legal run with both sides stalling.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int FIRST_WORDS   = 700;
    localparam int TOTAL_WORDS   = 1450;
    localparam int DRAIN_CYCLES  = 20;
    localparam int IDLE_PCT      = 30;
    localparam int QUIET_FROM    = 300;
    localparam int QUIET_TO      = 550;

    logic                       aclk;
    logic                       aresetn          = 1'b0;
    logic                       s_valid          = 1'b0;
    logic                       s_ready;
    logic [1:0]                 s_mode           = '0;
    logic                       s_dir_in         = 1'b0;
    logic [EP_BITS-1:0]         s_endpoint       = '0;
    logic [1:0]                 s_ep_type        = '0;
    logic [MPS_BITS-1:0]        s_max_packet     = '0;
    logic [ADDR_BITS-1:0]       s_buffer_addr    = '0;
    logic [FIELD_LEN_BITS-1:0]  s_length         = '0;
    logic [MPS_BITS-1:0]        s_received_count = '0;
    logic                       m_valid;
    logic                       m_ready          = 1'b0;
    logic [2:0]                 m_status;
    logic                       m_armed;
    logic [FIELD_LEN_BITS-1:0]  m_packet_len;
    logic [ADDR_BITS-1:0]       m_dma_addr;
    logic                       m_complete;
    logic [FIELD_LEN_BITS-1:0]  m_done_len;

    usb_endpoint_transfer_segmenter_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_dir_in         (s_dir_in),
        .s_endpoint       (s_endpoint),
        .s_ep_type        (s_ep_type),
        .s_max_packet     (s_max_packet),
        .s_buffer_addr    (s_buffer_addr),
        .s_length         (s_length),
        .s_received_count (s_received_count),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_armed          (m_armed),
        .m_packet_len     (m_packet_len),
        .m_dma_addr       (m_dma_addr),
        .m_complete       (m_complete),
        .m_done_len       (m_done_len)
    );

    // 8 ns clock.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Shadow of the endpoint records, indexed by dir_in * NUM_ENDPOINTS + ep.
    // Only the open flags of never-written entries decide a result; the other
    // fields matter only after an open, so clearing them is only for tidiness.
    // ------------------------------------------------------------------
    bit                     rec_open  [NREC];
    bit                     rec_burst [NREC];
    bit                     rec_armed [NREC];
    logic [MPS_BITS-1:0]    rec_mps   [NREC];
    logic [LEN_BITS-1:0]    rec_left  [NREC];
    logic [LEN_BITS-1:0]    rec_moved [NREC];
    logic [ADDR_BITS-1:0]   rec_addr  [NREC];

    item_t  pend_q[$];      // command words waiting for the driver
    res_t   result_q[$];    // results owed by the block, oldest first
    item_t  cur_word;       // word currently on the s_ payload ports
    res_t   want;

    int     words_queued  = 0;
    int     real_words    = 0;
    int     words_taken   = 0;
    int     results_seen  = 0;
    int     programmed    = 0;
    int     completions   = 0;
    int     rejects       = 0;
    int     mismatches    = 0;
    int     cycle_cnt     = 0;

    // Stimulus-side view of each record: just enough to shape transfers.
    bit     gen_ready [NREC];
    bit     gen_bulk  [NREC];
    int     gen_mps   [NREC];

    // Apply one command word to the shadow records and return the result it owes.
    function automatic res_t predict_segment(input item_t w);
        res_t                   r;
        int                     k;
        logic [LEN_BITS-1:0]    mps;
        logic [LEN_BITS-1:0]    rc;
        logic                   advance;
        r = '0;
        if (w.mode == MODE_NONE)
            return r;
        // Endpoint zero belongs to the control pipe: refuse it.
        if (w.endpoint == '0 || int'(w.endpoint) >= NUM_ENDPOINTS) begin
            r.status = STAT_DISABLED;
            return r;
        end
        k   = int'(w.dir_in) * NUM_ENDPOINTS + int'(w.endpoint);
        mps = LEN_BITS'(rec_mps[k]);
        rc  = LEN_BITS'(w.received_count);
        case (w.mode)
            MODE_OPEN: begin
                rec_open[k]  = 1'b1;
                rec_mps[k]   = w.max_packet;
                rec_burst[k] = (w.ep_type == TYPE_BULK);
                rec_armed[k] = 1'b0;
            end
            MODE_START: begin
                if (w.buffer_addr == '0 && w.len != '0) begin
                    r.status = STAT_NULL_BUF;
                end else if (!rec_open[k]) begin
                    r.status = STAT_DISABLED;
                end else if ((w.buffer_addr & ADDR_ALIGN_MASK) != '0) begin
                    r.status = STAT_MISALIGN;
                end else if (w.dir_in && rec_armed[k]) begin
                    r.status = STAT_BUSY;
                end else begin
                    // OUT may restart while armed; IN may not.
                    rec_left[k]  = w.len;
                    rec_moved[k] = '0;
                    rec_addr[k]  = w.buffer_addr;
                    rec_armed[k] = 1'b1;
                    r.armed      = 1'b1;
                    r.dma_addr   = w.buffer_addr;
                    if (rec_burst[k])
                        r.packet_len = w.len;
                    else
                        r.packet_len = (w.len < mps) ? w.len : mps;
                end
            end
            default: begin
                if (!rec_open[k]) begin
                    r.status = STAT_DISABLED;
                end else if (rec_armed[k]) begin
                    // Armed record: the packet (or burst) went out or came in.
                    rec_armed[k] = 1'b0;
                    if (rec_burst[k]) begin
                        r.complete = 1'b1;
                        r.done_len = w.dir_in ? rec_left[k] : rc;
                    end else begin
                        if (w.dir_in) begin
                            advance = (rec_left[k] > mps);
                            if (advance) begin
                                rec_left[k]  = rec_left[k] - mps;
                                rec_moved[k] = rec_moved[k] + mps;
                            end else begin
                                rec_moved[k] = rec_moved[k] + rec_left[k];
                                rec_left[k]  = '0;
                            end
                        end else begin
                            rec_moved[k] = rec_moved[k] + rc;
                            rec_left[k]  = (rec_left[k] > rc) ? rec_left[k] - rc : '0;
                            advance      = !(rc < mps || rec_left[k] == '0);
                        end
                        if (advance) begin
                            rec_addr[k]  = rec_addr[k] + ADDR_BITS'(mps);
                            rec_armed[k] = 1'b1;
                            r.armed      = 1'b1;
                            r.dma_addr   = rec_addr[k];
                            r.packet_len = (rec_left[k] < mps) ? rec_left[k] : mps;
                        end else begin
                            r.complete = 1'b1;
                            r.done_len = rec_moved[k];
                        end
                    end
                end
                // Enabled but not armed: spurious event, all fields stay zero.
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: present the next pending word, hold it until accepted.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : cmd_driver
        logic   took;
        logic   quiet;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            took  = s_valid && s_ready;
            quiet = (words_taken >= QUIET_FROM && words_taken < QUIET_TO);
            if (took) begin
                // Predict at acceptance so the shadow follows the block word by word.
                result_q.push_back(predict_segment(cur_word));
                words_taken++;
            end
            if ((!s_valid || took) && pend_q.size() != 0 &&
                (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
                cur_word         = pend_q.pop_front();
                s_mode           <= cur_word.mode;
                s_dir_in         <= cur_word.dir_in;
                s_endpoint       <= cur_word.endpoint;
                s_ep_type        <= cur_word.ep_type;
                s_max_packet     <= cur_word.max_packet;
                s_buffer_addr    <= cur_word.buffer_addr;
                s_length         <= cur_word.len;
                s_received_count <= cur_word.received_count;
                s_valid          <= 1'b1;
            end else if (took) begin
                s_valid <= 1'b0;
            end
        end
    end

    // Report one field that differs from its prediction.
    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: stall the result side at random, check every accepted word.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : res_monitor
        logic   quiet;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            quiet = (words_taken >= QUIET_FROM && words_taken < QUIET_TO);
            if (m_valid && m_ready) begin
                results_seen++;
                if (result_q.size() == 0) begin
                    $display("%0t ns: result with nothing expected, status %0d",
                             $time, m_status);
                    mismatches++;
                end else begin
                    want = result_q.pop_front();
                    check_field("status",     32'(want.status),     32'(m_status));
                    check_field("armed",      32'(want.armed),      32'(m_armed));
                    check_field("packet_len", 32'(want.packet_len), 32'(m_packet_len));
                    check_field("dma_addr",   32'(want.dma_addr),   32'(m_dma_addr));
                    check_field("complete",   32'(want.complete),   32'(m_complete));
                    check_field("done_len",   32'(want.done_len),   32'(m_done_len));
                end
                if (m_armed === 1'b1)
                    programmed++;
                if (m_complete === 1'b1)
                    completions++;
                if (m_status !== 3'(STAT_OK))
                    rejects++;
            end
            m_ready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: give up on a hung handshake.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d of %0d words taken, %0d results owed",
                     cycle_cnt, words_taken, words_queued, result_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus construction.
    // ------------------------------------------------------------------
    task automatic queue_word(input mode_t md, input bit dir, input int ep, input int typ,
                              input int mps, input logic [31:0] addr, input int len,
                              input int rc);
        item_t w;
        w.mode           = md;
        w.dir_in         = dir;
        w.endpoint       = EP_BITS'(ep);
        w.ep_type        = 2'(typ);
        w.max_packet     = MPS_BITS'(mps);
        w.buffer_addr    = addr;
        w.len            = LEN_BITS'(len);
        w.received_count = MPS_BITS'(rc);
        pend_q.push_back(w);
        words_queued++;
        // Ignored words do not count toward the stimulus volume.
        if (md != MODE_NONE && ep != 0)
            real_words++;
    endtask

    // Fully random word: any mode, any endpoint including zero.
    task automatic noise_word();
        queue_word(mode_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 7),
                   $urandom_range(0, 3), $urandom_range(0, 1024), $urandom,
                   $urandom_range(0, 65535), $urandom_range(0, 1024));
    endtask

    // One well-formed transfer: optional (re)open, start, then the packet events.
    task automatic gen_transfer();
        bit             dir;
        int             ep;
        int             k;
        int             typ;
        int             mps;
        int             len;
        int             npk;
        int             rc;
        logic [31:0]    addr;
        dir = 1'($urandom_range(0, 1));
        ep  = $urandom_range(1, NUM_ENDPOINTS - 1);
        k   = int'(dir) * NUM_ENDPOINTS + ep;
        if (!gen_ready[k] || $urandom_range(0, 1) == 0) begin
            typ = $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0:       mps = 0;
                1:       mps = 1;
                2:       mps = 8;
                3:       mps = 64;
                4:       mps = 512;
                5:       mps = 1024;
                default: mps = $urandom_range(1, 1024);
            endcase
            queue_word(MODE_OPEN, dir, ep, typ, mps, $urandom, $urandom_range(0, 65535),
                       $urandom_range(0, 1024));
            gen_ready[k] = 1'b1;
            gen_mps[k]   = mps;
            gen_bulk[k]  = (typ == int'(TYPE_BULK));
        end
        mps  = gen_mps[k];
        addr = $urandom & ~32'h3;
        // Salt in a few bad starts: misaligned, or null buffer (refused if length is nonzero).
        if ($urandom_range(0, 19) == 0)
            addr = addr | 32'($urandom_range(1, 3));
        else if ($urandom_range(0, 19) == 0)
            addr = '0;
        if ($urandom_range(0, 39) == 0 && (gen_bulk[k] || mps >= 512))
            len = 65535;
        else if (mps == 0)
            len = $urandom_range(0, 64);
        else
            len = $urandom_range(0, 4 * mps);
        queue_word(MODE_START, dir, ep, $urandom_range(0, 3), $urandom_range(0, 1024), addr,
                   len, $urandom_range(0, 1024));
        if (gen_bulk[k])
            npk = 1;
        else if (mps == 0)
            npk = $urandom_range(1, 3);
        else
            npk = len / mps + 1;
        // Now and then one event too many: lands on an idle record.
        if ($urandom_range(0, 3) == 0)
            npk++;
        repeat (npk) begin
            // OUT packets are mostly full; the rest are short or oversized.
            if (!dir && $urandom_range(0, 4) != 0)
                rc = mps;
            else
                rc = $urandom_range(0, 1024);
            queue_word(MODE_DONE, dir, ep, $urandom_range(0, 3), $urandom_range(0, 1024),
                       $urandom, $urandom_range(0, 65535), rc);
            if ($urandom_range(0, 9) == 0)
                noise_word();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: directed words, first random half, drain, second half, end.
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < NREC; i++) begin
            rec_open[i]  = 1'b0;
            rec_burst[i] = 1'b0;
            rec_armed[i] = 1'b0;
            rec_mps[i]   = '0;
            rec_left[i]  = '0;
            rec_moved[i] = '0;
            rec_addr[i]  = '0;
            gen_ready[i] = 1'b0;
            gen_bulk[i]  = 1'b0;
            gen_mps[i]   = 0;
        end

        // Directed: unused mode is ignored and endpoint zero is refused.
        queue_word(MODE_NONE, 1, 7, 3, 1024, 32'hFFFF_FFFF, 65535, 1024);
        queue_word(MODE_OPEN, 0, 0, 2, 64, 32'h0, 0, 0);
        // Refused starts and events on closed records.
        queue_word(MODE_START, 0, 3, 0, 0, 32'h100, 10, 0);
        queue_word(MODE_START, 0, 3, 0, 0, 32'h0, 5, 0);
        queue_word(MODE_DONE, 1, 5, 0, 0, 32'h0, 0, 0);
        // Bulk IN: spurious event, misaligned, full-length burst, busy, completion.
        queue_word(MODE_OPEN, 1, 1, 2, 512, 32'h0, 0, 0);
        queue_word(MODE_DONE, 1, 1, 0, 0, 32'h0, 0, 0);
        queue_word(MODE_START, 1, 1, 0, 0, 32'h1002, 100, 0);
        queue_word(MODE_START, 1, 1, 0, 0, 32'hFFFF_FFFC, 65535, 0);
        queue_word(MODE_START, 1, 1, 0, 0, 32'h40, 8, 0);
        queue_word(MODE_DONE, 1, 1, 0, 0, 32'h0, 0, 0);
        // Interrupt OUT: zero length at address zero, restart while armed,
        // full packets until remaining saturates at zero.
        queue_word(MODE_OPEN, 0, 7, 3, 1024, 32'h0, 0, 0);
        queue_word(MODE_START, 0, 7, 0, 0, 32'h0, 0, 0);
        queue_word(MODE_START, 0, 7, 0, 0, 32'h2000, 3000, 0);
        queue_word(MODE_DONE, 0, 7, 0, 0, 32'h0, 0, 1024);
        queue_word(MODE_DONE, 0, 7, 0, 0, 32'h0, 0, 1024);
        queue_word(MODE_DONE, 0, 7, 0, 0, 32'h0, 0, 1024);
        // Iso IN with zero max packet: stalls at length zero, then reopen.
        queue_word(MODE_OPEN, 1, 2, 1, 0, 32'h0, 0, 0);
        queue_word(MODE_START, 1, 2, 0, 0, 32'h40, 8, 0);
        queue_word(MODE_DONE, 1, 2, 0, 0, 32'h0, 0, 0);
        queue_word(MODE_OPEN, 1, 2, 3, 64, 32'h0, 0, 0);
        // Bulk OUT burst reports the received count; control OUT short packet.
        queue_word(MODE_OPEN, 0, 4, 2, 64, 32'h0, 0, 0);
        queue_word(MODE_START, 0, 4, 0, 0, 32'h80, 200, 0);
        queue_word(MODE_DONE, 0, 4, 0, 0, 32'h0, 0, 1024);
        queue_word(MODE_OPEN, 0, 6, 0, 64, 32'h0, 0, 0);
        queue_word(MODE_START, 0, 6, 0, 0, 32'h1000, 200, 0);
        queue_word(MODE_DONE, 0, 6, 0, 0, 32'h0, 0, 10);

        while (real_words < FIRST_WORDS) begin
            if ($urandom_range(0, 9) == 0)
                noise_word();
            else
                gen_transfer();
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Hold off the second half until every word is taken and no result is owed.
        while (words_taken != words_queued || result_q.size() != 0)
            @(posedge aclk);

        while (real_words < TOTAL_WORDS) begin
            if ($urandom_range(0, 9) == 0)
                noise_word();
            else
                gen_transfer();
        end

        while (words_taken != words_queued || result_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d command words and %0d results in %0d cycles",
                 words_taken, results_seen, cycle_cnt);
        $display("  %0d packets armed, %0d transfers completed, %0d words refused, %0d errors",
                 programmed, completions, rejects, mismatches);
        if (mismatches == 0 && result_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
